[src/wtosc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and types for the cubic wavetable oscillator.
// No dependencies.
package wtosc_pkg;

   localparam int TABLE_DEPTH   = 4096;
   localparam int ADDR_BITS     = $clog2(TABLE_DEPTH);
   localparam int SAMPLE_BITS   = 24;
   localparam int FRAC_BITS     = 16;
   localparam int PHASE_BITS    = 32;
   localparam int FREQ_BITS     = 24;
   localparam int RATE_BITS     = 24;
   localparam int LOG_BITS      = 4;
   localparam int INC_SHIFT     = 8;
   localparam int COEF_BITS     = SAMPLE_BITS + 3;
   localparam int ACC_BITS      = SAMPLE_BITS + 6;
   localparam int CMD_BITS      = 2;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 24;

   localparam int REQ_FIELD_BITS = FREQ_BITS + ADDR_BITS + SAMPLE_BITS + PHASE_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;

   localparam logic [LOG_BITS-1:0]  SIZE_LOG2_RESET = 4'd9;
   localparam logic [RATE_BITS-1:0] RATE_RESET      = 24'd89478;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_PHASE  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_SIZE_LOG2 = 2'd0,
      CSR_RATE      = 2'd1,
      CSR_ENABLE    = 2'd2
   } csr_type;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] a0;
      logic signed [COEF_BITS-1:0] a1;
      logic signed [COEF_BITS-1:0] a2;
      logic signed [COEF_BITS-1:0] a3;
      logic [FRAC_BITS-1:0]        frac;
   } horner_in_type;

endpackage

[src/wtosc_ram.sv]
`timescale 1ns / 1ps
// Single-port sample table, registered read, one access per cycle.
// Depends on wtosc_pkg.
module wtosc_ram (
   input  logic                                    clock,
   input  logic                                    en,
   input  logic                                    we,
   input  logic [wtosc_pkg::ADDR_BITS-1:0]         addr,
   input  logic [wtosc_pkg::SAMPLE_BITS-1:0]       wdata,
   output logic [wtosc_pkg::SAMPLE_BITS-1:0]       rdata
);
   import wtosc_pkg::*;

   logic [SAMPLE_BITS-1:0] mem [TABLE_DEPTH];
   logic [SAMPLE_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/wtosc_horner.sv]
`timescale 1ns / 1ps
// Horner evaluation of the interpolation cubic on one shared multiplier,
// three steps, followed by saturation. Depends on wtosc_pkg.
module wtosc_horner (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  wtosc_pkg::horner_in_type               hin,
   output logic                                   done,
   output logic signed [wtosc_pkg::SAMPLE_BITS-1:0] result
);
   import wtosc_pkg::*;

   localparam logic signed [ACC_BITS-1:0] SAT_MAX = ACC_BITS'((1 <<< (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [ACC_BITS-1:0] SAT_MIN = -SAT_MAX - ACC_BITS'(1);
   localparam int PROD_BITS = ACC_BITS + FRAC_BITS + 1;

   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;
   logic signed [COEF_BITS-1:0] coef_ff [3];
   logic [FRAC_BITS-1:0]        frac_ff;
   logic [1:0]                  step_ff, step_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic signed [PROD_BITS-1:0] prod;
   logic signed [ACC_BITS-1:0]  scaled;
   logic signed [COEF_BITS-1:0] coef_sel;

   always_comb begin
      prod     = acc_ff * $signed({1'b0, frac_ff});
      scaled   = prod[ACC_BITS+FRAC_BITS-1:FRAC_BITS];
      coef_sel = coef_ff[step_ff];
      acc_in   = acc_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         acc_in  = ACC_BITS'(hin.a0);
         step_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in  = scaled + ACC_BITS'(coef_sel);
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd2) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      acc_ff <= acc_in;
      if (start) begin
         coef_ff[0] <= hin.a1;
         coef_ff[1] <= hin.a2;
         coef_ff[2] <= hin.a3;
         frac_ff    <= hin.frac;
      end
   end

   always_comb begin
      if (acc_ff > SAT_MAX) begin
         result = SAMPLE_BITS'(SAT_MAX);
      end else if (acc_ff < SAT_MIN) begin
         result = SAMPLE_BITS'(SAT_MIN);
      end else begin
         result = SAMPLE_BITS'(acc_ff);
      end
   end

   assign done = done_ff;

   a_done_after_steps: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("horner done without a finished run");

   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start |=> (busy_ff || done_ff))
      else $error("horner run dropped");

   a_steps_bounded: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff != 2'd3)
      else $error("horner step overrun");

endmodule

[src/wavetable_oscillator_cubic.sv]
`timescale 1ns / 1ps
// Cubic wavetable oscillator. Sample word: the result register loads after 4 table reads,
// the coefficient step, 3 Horner steps, the handoff and the output step; the next word is
// taken once the sequencer is back in idle. Table write, set phase: done at accept;
// disabled-table sample: straight to the output step, zero result. A new word is taken
// while an earlier result may still wait in the output; a full output stalls the sequencer.
// Reset: config defaults, phase zero; table contents stay undefined until written.
module wavetable_oscillator_cubic (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // freq[23:0], table_index[35:24], table_value[59:36], phase_value[91:60], zeros
   input  logic [wtosc_pkg::REQ_DATA_BITS-1:0]       req_tdata,
   // cmd[1:0]
   input  logic [wtosc_pkg::CMD_BITS-1:0]            req_tuser,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // sample[23:0]
   output logic [wtosc_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   input  logic                                      csr_we,
   input  logic [wtosc_pkg::CSR_ADDR_BITS-1:0]       csr_addr,
   input  logic [wtosc_pkg::CSR_DATA_BITS-1:0]       csr_wdata
);
   import wtosc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_COEF = 5'b00100,
      S_HORN = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   localparam logic [LOG_BITS-1:0] MAX_LOG = LOG_BITS'(ADDR_BITS);
   localparam int SHIFT_BITS = $clog2(PHASE_BITS) + 1;
   localparam int PROD_BITS  = FREQ_BITS + RATE_BITS + 1;

   state_type                      state_ff, state_in;
   logic [LOG_BITS-1:0]            size_log2_ff;
   logic [RATE_BITS-1:0]           rate_ff;
   logic                           enable_ff;
   logic [PHASE_BITS-1:0]          phase_acc_ff, phase_acc_in;
   logic [ADDR_BITS-1:0]           base_ff, mask_ff;
   logic [FRAC_BITS-1:0]           frac_ff;
   logic signed [FREQ_BITS-1:0]    freq_ff;
   logic signed [PROD_BITS-1:0]    inc_prod_ff;
   logic                           gen_ff;
   logic [1:0]                     rd_cnt_ff;
   logic                           rd_vld_ff;
   logic [1:0]                     rd_idx_ff;
   logic signed [SAMPLE_BITS-1:0]  pa_ff, pb_ff, pc_ff;
   logic                           rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]         rsp_data_ff;

   logic                           req_fire, out_free, out_load;
   logic [FREQ_BITS-1:0]           f_freq;
   logic [ADDR_BITS-1:0]           f_index;
   logic [SAMPLE_BITS-1:0]         f_value;
   logic [PHASE_BITS-1:0]          f_phase;
   logic [LOG_BITS-1:0]            l;
   logic [PHASE_BITS-1:0]          phase_shl;
   logic [SHIFT_BITS-1:0]          base_shamt;
   logic                           ram_en, ram_we;
   logic [ADDR_BITS-1:0]           ram_addr;
   logic [SAMPLE_BITS-1:0]         ram_rdata;
   horner_in_type                  hin;
   logic                           hr_start, hr_done;
   logic signed [SAMPLE_BITS-1:0]  hr_result;
   logic signed [COEF_BITS-1:0]    ea, eb, ec, ed;

   assign f_freq  = req_tdata[FREQ_BITS-1:0];
   assign f_index = req_tdata[FREQ_BITS+ADDR_BITS-1:FREQ_BITS];
   assign f_value = req_tdata[FREQ_BITS+ADDR_BITS+SAMPLE_BITS-1:FREQ_BITS+ADDR_BITS];
   assign f_phase = req_tdata[REQ_FIELD_BITS-1:FREQ_BITS+ADDR_BITS+SAMPLE_BITS];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign out_load   = (state_ff == S_OUT) && out_free;

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         size_log2_ff <= SIZE_LOG2_RESET;
         rate_ff      <= RATE_RESET;
         enable_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SIZE_LOG2: size_log2_ff <= csr_wdata[LOG_BITS-1:0];
            CSR_RATE:      rate_ff      <= csr_wdata[RATE_BITS-1:0];
            CSR_ENABLE:    enable_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // table geometry from the current phase
   always_comb begin
      if (size_log2_ff < LOG_BITS'(1)) begin
         l = LOG_BITS'(1);
      end else if (size_log2_ff > MAX_LOG) begin
         l = MAX_LOG;
      end else begin
         l = size_log2_ff;
      end
      base_shamt = SHIFT_BITS'(PHASE_BITS) - SHIFT_BITS'(l);
      phase_shl  = phase_acc_ff << l;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_acc_in = phase_acc_ff;
      hr_start     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  CMD_SAMPLE: state_in = enable_ff ? S_READ : S_OUT;
                  CMD_PHASE:  phase_acc_in = f_phase;
                  default: ;
               endcase
            end
         end
         S_READ: begin
            if (rd_cnt_ff == 2'd3) begin
               state_in = S_COEF;
            end
         end
         S_COEF: begin
            hr_start = 1'b1;
            state_in = S_HORN;
         end
         S_HORN: begin
            if (hr_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
               if (gen_ff) begin
                  phase_acc_in = phase_acc_ff +
                     inc_prod_ff[PHASE_BITS+INC_SHIFT-1:INC_SHIFT];
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_acc_ff <= '0;
         rd_cnt_ff    <= 2'd0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_acc_ff <= phase_acc_in;
         rd_vld_ff    <= (state_ff == S_READ);
         if (state_ff == S_READ) begin
            rd_cnt_ff <= rd_cnt_ff + 2'd1;
         end else begin
            rd_cnt_ff <= 2'd0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         base_ff <= ADDR_BITS'(phase_acc_ff >> base_shamt);
         mask_ff <= ADDR_BITS'(({{ADDR_BITS{1'b0}}, 1'b1} << l) - 1'b1);
         frac_ff <= phase_shl[PHASE_BITS-1:PHASE_BITS-FRAC_BITS];
         freq_ff <= $signed(f_freq);
         gen_ff  <= enable_ff;
      end
      inc_prod_ff <= freq_ff * $signed({1'b0, rate_ff});
      rd_idx_ff   <= rd_cnt_ff;
      if (rd_vld_ff) begin
         case (rd_idx_ff)
            2'd0:    pa_ff <= $signed(ram_rdata);
            2'd1:    pb_ff <= $signed(ram_rdata);
            2'd2:    pc_ff <= $signed(ram_rdata);
            default: ;
         endcase
      end
      if (out_load) begin
         rsp_data_ff <= gen_ff ? hr_result : '0;
      end
   end

   // table port: writes from idle, point reads from the sequencer
   always_comb begin
      ram_we   = req_fire && (req_tuser == CMD_WRITE);
      ram_en   = ram_we || (state_ff == S_READ);
      ram_addr = ram_we ? f_index : ((base_ff + ADDR_BITS'(rd_cnt_ff)) & mask_ff);
   end

   wtosc_ram u_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (f_value),
      .rdata (ram_rdata)
   );

   // cubic fit; the fourth point arrives from the memory in this cycle
   always_comb begin
      ea      = COEF_BITS'(pa_ff);
      eb      = COEF_BITS'(pb_ff);
      ec      = COEF_BITS'(pc_ff);
      ed      = COEF_BITS'($signed(ram_rdata));
      hin.a0  = ed - ec - ea + eb;
      hin.a1  = ea - eb - hin.a0;
      hin.a2  = ec - ea;
      hin.a3  = eb;
      hin.frac = frac_ff;
   end

   wtosc_horner u_horner (
      .clock  (clock),
      .reset  (reset),
      .start  (hr_start),
      .hin    (hin),
      .done   (hr_done),
      .result (hr_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_data_ff);

   a_done_in_horn: assert property (@(posedge clock) disable iff (reset)
      hr_done |-> state_ff == S_HORN)
      else $error("horner result outside evaluation state");

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff)
      else $error("finished sample not presented");

   a_phase_moves: assert property (@(posedge clock) disable iff (reset)
      !$stable(phase_acc_ff) |-> ($past(state_ff) == S_OUT || $past(req_fire)))
      else $error("phase changed outside set or advance");

   a_reads_in_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COEF |-> rd_vld_ff && rd_idx_ff == 2'd3)
      else $error("fourth table point not ready for fit");

endmodule
